FILE: hdl/sjf_pkg.sv
package sjf_pkg;

  localparam int TASK_SLOTS   = 16;
  localparam int ID_BITS      = 8;

  // payload widths of the channels
  localparam int TASK_ID_BITS = 8;
  localparam int BURST_BITS   = 16;
  localparam int STATUS_BITS  = 2;

  // identifier bits that are kept in a slot
  localparam int SID_BITS  = (ID_BITS < TASK_ID_BITS) ? ID_BITS : TASK_ID_BITS;
  localparam int SLOT_BITS = $clog2(TASK_SLOTS);
  // live task count, 0 .. TASK_SLOTS
  localparam int CNT_BITS  = SLOT_BITS + 1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_PICK = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_PICKED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // one slot of the task memory
  typedef struct packed {
    logic [SID_BITS-1:0]   id;
    logic [BURST_BITS-1:0] len;
    logic [SLOT_BITS-1:0]  stamp;
  } entry_t;

endpackage

FILE: hdl/sjf_req_if.sv
interface sjf_req_if import sjf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [BURST_BITS-1:0]   burst;

  modport source (output valid, output op, output task_id, output burst, input ready);
  modport sink (input valid, input op, input task_id, input burst, output ready);
endinterface

FILE: hdl/sjf_res_if.sv
interface sjf_res_if import sjf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [TASK_ID_BITS-1:0] picked_id;
  logic [BURST_BITS-1:0]   picked_burst;

  modport source (output valid, output status, output picked_id, output picked_burst,
                  input ready);
  modport sink (input valid, input status, input picked_id, input picked_burst,
                output ready);
endinterface

FILE: hdl/shortest_job_first_select.sv
// add: slot written in S_ADD, then S_DONE; a pick on an empty table goes straight to S_DONE
// pick: two sweeps over the slot memory read port:
//   one to find the shortest task, one to close the gap it leaves in the arrival ranks
// one request in flight at a time; a new request is taken while the last result still waits
// rst (synchronous) empties the table, clears the rank counter and drops any pending result;
// slot memory contents are not cleared, only slots flagged in use are ever looked at
module shortest_job_first_select import sjf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sjf_req_if.sink   req,
  sjf_res_if.source res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // per-slot in-use flags kept in flops, everything else in the slot memory
  logic [TASK_SLOTS-1:0] used;
  logic [CNT_BITS-1:0]   arrival_count;

  // slot memory, one write and one registered read per cycle
  entry_t               mem [TASK_SLOTS];
  entry_t               rd_entry;
  logic [SLOT_BITS-1:0] rd_addr;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  entry_t               mem_wdata;

  // latched add request
  logic [SID_BITS-1:0]   req_id;
  logic [BURST_BITS-1:0] req_len;

  // sweep counter and the compare stage that trails it in the next cycle
  logic [CNT_BITS-1:0]  scan_cnt;
  logic                 issue;
  logic                 cmp_live;
  logic [SLOT_BITS-1:0] cmp_idx;
  logic                 take;
  logic                 shift_down;

  // running best candidate of a pick
  logic                  best_found;
  logic [SLOT_BITS-1:0]  best_idx;
  logic [SID_BITS-1:0]   best_id;
  logic [BURST_BITS-1:0] best_len;
  logic [SLOT_BITS-1:0]  best_stamp;

  // lowest free slot
  logic                 free_found;
  logic [SLOT_BITS-1:0] free_idx;

  // finished result, waiting for the output register
  status_t               done_status;
  logic [TASK_ID_BITS-1:0] done_id;
  logic [BURST_BITS-1:0] done_len;

  // output register
  logic                    out_valid;
  status_t                 out_status;
  logic [TASK_ID_BITS-1:0] out_id;
  logic [BURST_BITS-1:0]   out_len;
  logic                    out_load;

  logic req_take;

  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.picked_id    = out_id;
  assign res.picked_burst = out_len;

  assign out_load = (state == S_DONE) && (!out_valid || res.ready);

  // priority search for the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_BITS'(i);
      end
    end
  end

  assign issue   = ((state == S_SCAN) || (state == S_FIX)) &&
                   (scan_cnt < CNT_BITS'(TASK_SLOTS));
  assign rd_addr = scan_cnt[SLOT_BITS-1:0];

  // shorter burst wins, on equal burst the newer arrival rank wins
  assign take = !best_found || (rd_entry.len < best_len) ||
                ((rd_entry.len == best_len) && (rd_entry.stamp > best_stamp));

  // ranks above the removed task close up by one
  assign shift_down = (state == S_FIX) && cmp_live && used[cmp_idx] &&
                      (rd_entry.stamp > best_stamp);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{id: req_id, len: req_len, stamp: arrival_count[SLOT_BITS-1:0]};
    if (state == S_ADD) begin
      mem_we = free_found;
    end else if (shift_down) begin
      mem_we          = 1'b1;
      mem_waddr       = cmp_idx;
      mem_wdata       = rd_entry;
      mem_wdata.stamp = rd_entry.stamp - SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (req_take) begin
      req_id  <= req.task_id[SID_BITS-1:0];
      req_len <= req.burst;
    end
    if ((state == S_SCAN) && cmp_live && used[cmp_idx] && take) begin
      best_idx   <= cmp_idx;
      best_id    <= rd_entry.id;
      best_len   <= rd_entry.len;
      best_stamp <= rd_entry.stamp;
    end
    if (out_load) begin
      out_status <= done_status;
      out_id     <= done_id;
      out_len    <= done_len;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      arrival_count <= '0;
      scan_cnt      <= '0;
      cmp_live      <= 1'b0;
      best_found    <= 1'b0;
      out_valid     <= 1'b0;
      done_status   <= ST_ADDED;
      done_id       <= '0;
      done_len      <= '0;
    end else begin
      cmp_live <= issue;
      if (issue) begin
        scan_cnt <= scan_cnt + CNT_BITS'(1);
      end
      if ((state == S_SCAN) && cmp_live && used[cmp_idx] && take) begin
        best_found <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            if (req.op == OP_ADD) begin
              state <= S_ADD;
            end else if (used == '0) begin
              done_status <= ST_EMPTY;
              done_id     <= '0;
              done_len    <= '0;
              state       <= S_DONE;
            end else begin
              scan_cnt   <= '0;
              best_found <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_ADD: begin
          done_id  <= '0;
          done_len <= '0;
          if (free_found) begin
            used[free_idx] <= 1'b1;
            arrival_count  <= arrival_count + CNT_BITS'(1);
            done_status    <= ST_ADDED;
          end else begin
            done_status <= ST_FULL;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // last compare lands at this edge
          if (!issue) begin
            scan_cnt <= '0;
            state    <= S_FIX;
          end
        end
        S_FIX: begin
          if (!issue) begin
            used[best_idx] <= 1'b0;
            arrival_count  <= arrival_count - CNT_BITS'(1);
            done_status    <= ST_PICKED;
            done_id        <= TASK_ID_BITS'(best_id);
            done_len       <= best_len;
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // rank counter tracks the number of live tasks
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(arrival_count))
    else $error("live task count and rank counter disagree");

  // a result only enters the output register from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result offered without a finished request");

  // the rank fix-up sweep always has a chosen task
  a_fix_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> best_found)
    else $error("fix-up sweep without a picked task");

  // the fix-up sweep never rewrites the slot being removed
  a_fix_not_best: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIX) && mem_we) |-> (mem_waddr != best_idx))
    else $error("rank fix-up wrote the removed slot");

  // memory is only written while adding or closing up ranks
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_ADD) || (state == S_FIX)))
    else $error("slot memory written outside add or fix-up");

endmodule

FILE: tb/sv/shortest_job_first_select_tb.sv
`timescale 1ns / 100ps

import sjf_pkg::*;

// one expected answer of the task table
typedef struct {
  status_t               status;
  logic [TASK_ID_BITS-1:0] id;
  logic [BURST_BITS-1:0]   len;
} sjf_outcome_t;

class sjf_scoreboard;
  logic                  slot_busy [TASK_SLOTS];
  logic [SID_BITS-1:0]   slot_id   [TASK_SLOTS];
  logic [BURST_BITS-1:0] slot_len  [TASK_SLOTS];
  int unsigned           slot_rank [TASK_SLOTS];
  int unsigned           live_count;
  sjf_outcome_t          due_q [$];
  int unsigned           mismatches;
  int unsigned           checked;
  int unsigned           n_added, n_full, n_picked, n_empty, n_ties;

  function new();
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    live_count = 0;
    mismatches = 0;
    checked    = 0;
    n_added    = 0;
    n_full     = 0;
    n_picked   = 0;
    n_empty    = 0;
    n_ties     = 0;
  endfunction

  function int unsigned pending();
    return due_q.size();
  endfunction

  // update the table copy for an accepted request and queue its answer
  function void note_request(logic op, logic [TASK_ID_BITS-1:0] id,
                             logic [BURST_BITS-1:0] len);
    sjf_outcome_t ans;
    int           slot;
    int           same_len;
    ans.status = ST_ADDED;
    ans.id     = '0;
    ans.len    = '0;
    slot       = -1;
    same_len   = 0;
    if (op == OP_ADD) begin
      for (int i = 0; i < TASK_SLOTS; i++)
        if (!slot_busy[i] && slot < 0) slot = i;
      if (slot < 0) begin
        ans.status = ST_FULL;
        n_full++;
      end else begin
        slot_busy[slot] = 1'b1;
        slot_id[slot]   = id[SID_BITS-1:0];
        slot_len[slot]  = len;
        slot_rank[slot] = live_count;
        live_count++;
        n_added++;
      end
    end else begin
      // shortest burst wins, newest arrival on a tie
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (slot_busy[i]) begin
          if (slot < 0 || slot_len[i] < slot_len[slot] ||
              (slot_len[i] == slot_len[slot] && slot_rank[i] > slot_rank[slot]))
            slot = i;
        end
      end
      if (slot < 0) begin
        ans.status = ST_EMPTY;
        n_empty++;
      end else begin
        for (int i = 0; i < TASK_SLOTS; i++)
          if (slot_busy[i] && slot_len[i] == slot_len[slot]) same_len++;
        if (same_len > 1) n_ties++;
        slot_busy[slot] = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++)
          if (slot_busy[i] && slot_rank[i] > slot_rank[slot]) slot_rank[i]--;
        live_count--;
        ans.status = ST_PICKED;
        ans.id     = TASK_ID_BITS'(slot_id[slot]);
        ans.len    = slot_len[slot];
        n_picked++;
      end
    end
    due_q.push_back(ans);
  endfunction

  function void check_result(logic [STATUS_BITS-1:0] st, logic [TASK_ID_BITS-1:0] id,
                             logic [BURST_BITS-1:0] len);
    sjf_outcome_t ans;
    checked++;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing outstanding: status %0d id %0d burst %0d",
                 $realtime, st, id, len);
      return;
    end
    ans = due_q.pop_front();
    if (st !== ans.status || id !== ans.id || len !== ans.len) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch, expected status %0d id %0d burst %0d, got %0d %0d %0d",
                 $realtime, ans.status, ans.id, ans.len, st, id, len);
    end
  endfunction
endclass

module shortest_job_first_select_tb;

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RANDOM_ITEMS = 660;
  // a pick sweeps the slot memory twice, so this comfortably covers the tail
  localparam int          DRAIN_CYCLES = 4 * TASK_SLOTS + 20;
  localparam logic [15:0] SEED_BURSTS [0:15] = '{
    16'd500, 16'd0, 16'd65535, 16'd100, 16'd100, 16'd7, 16'd100, 16'd65535,
    16'd1, 16'd0, 16'd300, 16'd42, 16'd42, 16'd9, 16'd1000, 16'd65534
  };

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_request;
  int unsigned hold_left;
  int unsigned cycle_count;

  sjf_scoreboard sb = new();

  sjf_req_if req ();
  sjf_res_if res ();

  shortest_job_first_select DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, sb.pending());
      $display("shortest_job_first_select_tb failed");
      $finish;
    end
  end

  // result side: ready changes on the falling edge, random idling plus an
  // optional long hold-off that is counted here in cycles
  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_left        = HOLD_CYCLES;
      hold_off_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // results are taken on the rising edge and checked in arrival order
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.status, res.picked_id, res.picked_burst);
  end

  // offer one request, idling beforehand at the current rate, and hand it to
  // the scoreboard at the edge where it is taken
  task automatic send_request(input logic op, input logic [TASK_ID_BITS-1:0] id,
                              input logic [BURST_BITS-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.op      <= op;
    req.task_id <= id;
    req.burst   <= len;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, id, len);
  endtask

  initial begin
    int unsigned add_bias;
    logic        op;
    logic [15:0] len;

    // every input known from time zero
    clk              = 1'b0;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.op           = OP_ADD;
    req.task_id      = '0;
    req.burst        = '0;
    res.ready        = 1'b0;
    hold_off_request = 1'b0;
    hold_left        = 0;
    cycle_count      = 0;
    send_idle_pct    = 21;
    recv_idle_pct    = 61;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    // pick from an empty table, with all-ones in the ignored fields
    send_request(OP_PICK, 8'hFF, 16'hFFFF);
    // fill every slot: ids cover 0 and 255, bursts cover both extremes and
    // several ties (two at zero, three at 100, two at 65535, two at 42)
    for (int i = 0; i < TASK_SLOTS; i++)
      send_request(OP_ADD, TASK_ID_BITS'(i * 17), SEED_BURSTS[i]);
    // table full, this add must be turned away
    send_request(OP_ADD, 8'hAA, 16'd5);
    // drain a few: the newer zero-burst task must come out first
    repeat (6) send_request(OP_PICK, 8'h55, 16'hAAAA);

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // block the result side for a long stretch while requests keep coming
          hold_off_request = 1'b1;
        end
      endcase
      add_bias = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // the add/pick mix shifts every few dozen requests so the table
        // swings between empty and full
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: add_bias = 25;
            1: add_bias = 50;
            2: add_bias = 75;
            default: add_bias = 90;
          endcase
        end
        op = ($urandom_range(99) < add_bias) ? OP_ADD : OP_PICK;
        // mostly tiny bursts so ties are common, with extremes and wide values
        case ($urandom_range(7))
          0: len = 16'h0000;
          1: len = 16'hFFFF;
          2, 3: len = 16'($urandom_range(65535));
          default: len = 16'($urandom_range(7));
        endcase
        send_request(op, 8'($urandom_range(255)), len);
      end
    end

    @(negedge clk);
    req.valid <= 1'b0;

    // wait for every outstanding answer, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d adds stored, %0d turned away on a full table, %0d picks served",
             sb.n_added, sb.n_full, sb.n_picked);
    $display("%0d picks on an empty table, %0d tie-breaks on burst, %0d results checked",
             sb.n_empty, sb.n_ties, sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("shortest_job_first_select_tb passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("shortest_job_first_select_tb failed");
    end
    $finish;
  end

endmodule
